// ===== sv/prs_pkg.sv =====
`default_nettype none

package prs_pkg;

  localparam int VAL_W  = 8;
  localparam int PAIR_W = 2 * VAL_W;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_CLR  = 6'b000010,
    ST_HIST = 6'b000100,
    ST_PFX  = 6'b001000,
    ST_SCAT = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_KEY  = 3'b010,
    PH_UPD  = 3'b100
  } phase_t;

endpackage

`default_nettype wire

// ===== sv/prs_if.sv =====
`default_nettype none

interface prs_in_if;
  logic                     valid;
  logic                     ready;
  logic [prs_pkg::VAL_W-1:0] first_value;
  logic [prs_pkg::VAL_W-1:0] second_value;
  logic                     last_pair;

  modport source (output valid, first_value, second_value, last_pair, input ready);
  modport sink (input valid, first_value, second_value, last_pair, output ready);
endinterface

interface prs_out_if;
  logic                     valid;
  logic                     ready;
  logic [prs_pkg::VAL_W-1:0] sorted_first;
  logic [prs_pkg::VAL_W-1:0] sorted_second;
  logic                     last_result;
  logic                     overflow;

  modport source (output valid, sorted_first, sorted_second, last_result, overflow,
                  input ready);
  modport sink (input valid, sorted_first, sorted_second, last_result, overflow,
                output ready);
endinterface

`default_nettype wire

// ===== sv/pair_radix_sort_top.sv =====
// Loading takes one cycle per pair beat; the input is ready only while a set is loading.
// After the last pair come two sort passes over the stored pairs and R = 2^min(KEY_BITS,8)
// keys: each pass clears and prefix-sums the count memory at one entry a cycle, and counts
// and scatters one pair at a time through its address, key and update phases.
// Each result is read out in the emit address and key phases and held valid until it is taken.
// Synchronous reset clears the control state and empties the set; the pair memories need none.
`default_nettype none

module pair_radix_sort_top #(
  parameter int MAX_PAIRS = 64,
  parameter int KEY_BITS  = 8
) (
  input wire logic  clk,
  input wire logic  rst_n,
  prs_in_if.sink    in_chan,
  prs_out_if.source out_chan
);

  import prs_pkg::*;

  localparam int KEY_W     = (KEY_BITS < VAL_W) ? KEY_BITS : VAL_W;
  localparam int KEY_RANGE = 1 << KEY_W;
  localparam int IDX_W     = $clog2(MAX_PAIRS);
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

  logic              ps_we, pb_we, kc_we;
  logic [IDX_W-1:0]  ps_waddr, ps_raddr, pb_waddr, pb_raddr;
  logic [PAIR_W-1:0] ps_wdata, ps_rdata, pb_wdata, pb_rdata;
  logic [KEY_W-1:0]  kc_waddr, kc_raddr;
  logic [CNT_W-1:0]  kc_wdata, kc_rdata;

  prs_ram #(.DEPTH(MAX_PAIRS), .WIDTH(PAIR_W)) u_pair_store (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  prs_ram #(.DEPTH(MAX_PAIRS), .WIDTH(PAIR_W)) u_pass_buffer (
    .clk   (clk),
    .we    (pb_we),
    .waddr (pb_waddr),
    .wdata (pb_wdata),
    .raddr (pb_raddr),
    .rdata (pb_rdata)
  );

  prs_ram #(.DEPTH(KEY_RANGE), .WIDTH(CNT_W)) u_key_counts (
    .clk   (clk),
    .we    (kc_we),
    .waddr (kc_waddr),
    .wdata (kc_wdata),
    .raddr (kc_raddr),
    .rdata (kc_rdata)
  );

  prs_seq #(.MAX_PAIRS(MAX_PAIRS), .KEY_W(KEY_W)) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_first_value    (in_chan.first_value),
    .in_second_value   (in_chan.second_value),
    .in_last_pair      (in_chan.last_pair),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_sorted_first  (out_chan.sorted_first),
    .out_sorted_second (out_chan.sorted_second),
    .out_last_result   (out_chan.last_result),
    .out_overflow      (out_chan.overflow),
    .ps_we             (ps_we),
    .ps_waddr          (ps_waddr),
    .ps_wdata          (ps_wdata),
    .ps_raddr          (ps_raddr),
    .ps_rdata          (ps_rdata),
    .pb_we             (pb_we),
    .pb_waddr          (pb_waddr),
    .pb_wdata          (pb_wdata),
    .pb_raddr          (pb_raddr),
    .pb_rdata          (pb_rdata),
    .kc_we             (kc_we),
    .kc_waddr          (kc_waddr),
    .kc_wdata          (kc_wdata),
    .kc_raddr          (kc_raddr),
    .kc_rdata          (kc_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/prs_ram.sv =====
`default_nettype none

module prs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/prs_seq.sv =====
`default_nettype none

module prs_seq #(
  parameter int MAX_PAIRS = 64,
  parameter int KEY_W     = 8,
  localparam int IDX_W = $clog2(MAX_PAIRS),
  localparam int CNT_W = $clog2(MAX_PAIRS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [prs_pkg::VAL_W-1:0]  in_first_value,
  input  wire logic [prs_pkg::VAL_W-1:0]  in_second_value,
  input  wire logic                       in_last_pair,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [prs_pkg::VAL_W-1:0]  out_sorted_first,
  output logic      [prs_pkg::VAL_W-1:0]  out_sorted_second,
  output logic                            out_last_result,
  output logic                            out_overflow,
  output logic                            ps_we,
  output logic      [IDX_W-1:0]           ps_waddr,
  output logic      [prs_pkg::PAIR_W-1:0] ps_wdata,
  output logic      [IDX_W-1:0]           ps_raddr,
  input  wire logic [prs_pkg::PAIR_W-1:0] ps_rdata,
  output logic                            pb_we,
  output logic      [IDX_W-1:0]           pb_waddr,
  output logic      [prs_pkg::PAIR_W-1:0] pb_wdata,
  output logic      [IDX_W-1:0]           pb_raddr,
  input  wire logic [prs_pkg::PAIR_W-1:0] pb_rdata,
  output logic                            kc_we,
  output logic      [KEY_W-1:0]           kc_waddr,
  output logic      [CNT_W-1:0]           kc_wdata,
  output logic      [KEY_W-1:0]           kc_raddr,
  input  wire logic [CNT_W-1:0]           kc_rdata
);

  import prs_pkg::*;

  localparam logic [VAL_W-1:0] KEY_MASK = VAL_W'((1 << KEY_W) - 1);

  state_t             state_r, state_nxt;
  phase_t             ph_r, ph_nxt;
  logic               pass_r, pass_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [KEY_W:0]     kc_r, kc_nxt;
  logic               rvld_r, rvld_nxt;
  logic [KEY_W-1:0]   raddr_r, raddr_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAIR_W-1:0]  pair_r, pair_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [PAIR_W-1:0]  out_pair_r, out_pair_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               in_fire;
  logic               out_fire;
  logic [PAIR_W-1:0]  src_rd;
  logic [VAL_W-1:0]   src_val;
  logic [KEY_W-1:0]   src_key;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W-1:0]   pfx_sum;
  logic [CNT_W-1:0]   idx_m1;

  assign in_ready          = (state_r == ST_LOAD);
  assign in_fire           = in_valid && in_ready;
  assign out_valid         = out_vld_r;
  assign out_fire          = out_vld_r && out_ready;
  assign out_sorted_first  = out_pair_r[PAIR_W-1:VAL_W];
  assign out_sorted_second = out_pair_r[VAL_W-1:0];
  assign out_last_result   = out_last_r;
  assign out_overflow      = out_ovf_r;

  assign src_rd  = pass_r ? pb_rdata : ps_rdata;
  assign src_val = pass_r ? src_rd[PAIR_W-1:VAL_W] : src_rd[VAL_W-1:0];
  assign src_key = src_val[KEY_W-1:0];
  assign cnt_dec = (kc_rdata != '0) ? kc_rdata - CNT_W'(1) : kc_rdata;
  assign pfx_sum = acc_r + kc_rdata;
  assign idx_m1  = idx_r - CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    pass_nxt     = pass_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    kc_nxt       = kc_r;
    rvld_nxt     = rvld_r;
    raddr_nxt    = raddr_r;
    acc_nxt      = acc_r;
    key_nxt      = key_r;
    pair_nxt     = pair_r;
    out_vld_nxt  = out_vld_r;
    out_pair_nxt = out_pair_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;

    ps_we    = 1'b0;
    ps_waddr = cnt_dec[IDX_W-1:0];
    ps_wdata = pair_r;
    ps_raddr = idx_r[IDX_W-1:0];
    pb_we    = 1'b0;
    pb_waddr = cnt_dec[IDX_W-1:0];
    pb_wdata = pair_r;
    pb_raddr = idx_r[IDX_W-1:0];
    kc_we    = 1'b0;
    kc_waddr = key_r;
    kc_wdata = '0;
    kc_raddr = src_key;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_r < CNT_W'(MAX_PAIRS)) begin
            ps_we    = 1'b1;
            ps_waddr = cnt_r[IDX_W-1:0];
            ps_wdata = {in_first_value & KEY_MASK, in_second_value & KEY_MASK};
            cnt_nxt  = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_pair) begin
            state_nxt = ST_CLR;
            pass_nxt  = 1'b0;
            kc_nxt    = '0;
          end
        end
      end
      ST_CLR: begin
        kc_we    = 1'b1;
        kc_waddr = kc_r[KEY_W-1:0];
        kc_wdata = '0;
        kc_nxt   = kc_r + (KEY_W+1)'(1);
        if (kc_r[KEY_W-1:0] == '1) begin
          state_nxt = ST_HIST;
          idx_nxt   = '0;
          ph_nxt    = PH_ADDR;
        end
      end
      ST_HIST: begin
        unique case (ph_r)
          PH_ADDR: begin
            ph_nxt = PH_KEY;
          end
          PH_KEY: begin
            kc_raddr = src_key;
            key_nxt  = src_key;
            ph_nxt   = PH_UPD;
          end
          PH_UPD: begin
            kc_we    = 1'b1;
            kc_waddr = key_r;
            kc_wdata = kc_rdata + CNT_W'(1);
            idx_nxt  = idx_r + CNT_W'(1);
            ph_nxt   = PH_ADDR;
            if (idx_r + CNT_W'(1) == cnt_r) begin
              state_nxt = ST_PFX;
              kc_nxt    = '0;
              rvld_nxt  = 1'b0;
              acc_nxt   = '0;
            end
          end
          default: ph_nxt = PH_ADDR;
        endcase
      end
      ST_PFX: begin
        kc_raddr  = kc_r[KEY_W-1:0];
        rvld_nxt  = !kc_r[KEY_W];
        raddr_nxt = kc_r[KEY_W-1:0];
        if (!kc_r[KEY_W]) begin
          kc_nxt = kc_r + (KEY_W+1)'(1);
        end
        if (rvld_r) begin
          kc_we    = 1'b1;
          kc_waddr = raddr_r;
          kc_wdata = pfx_sum;
          acc_nxt  = pfx_sum;
          if (raddr_r == '1) begin
            state_nxt = ST_SCAT;
            rvld_nxt  = 1'b0;
            idx_nxt   = cnt_r;
            ph_nxt    = PH_ADDR;
          end
        end
      end
      ST_SCAT: begin
        unique case (ph_r)
          PH_ADDR: begin
            ps_raddr = idx_m1[IDX_W-1:0];
            pb_raddr = idx_m1[IDX_W-1:0];
            ph_nxt   = PH_KEY;
          end
          PH_KEY: begin
            kc_raddr = src_key;
            key_nxt  = src_key;
            pair_nxt = src_rd;
            ph_nxt   = PH_UPD;
          end
          PH_UPD: begin
            kc_we    = 1'b1;
            kc_waddr = key_r;
            kc_wdata = cnt_dec;
            if (cnt_dec < CNT_W'(MAX_PAIRS)) begin
              if (pass_r) begin
                ps_we = 1'b1;
              end else begin
                pb_we = 1'b1;
              end
            end
            idx_nxt = idx_m1;
            ph_nxt  = PH_ADDR;
            if (idx_r == CNT_W'(1)) begin
              if (!pass_r) begin
                state_nxt = ST_CLR;
                pass_nxt  = 1'b1;
                kc_nxt    = '0;
              end else begin
                state_nxt = ST_EMIT;
                pass_nxt  = 1'b0;
                idx_nxt   = '0;
              end
            end
          end
          default: ph_nxt = PH_ADDR;
        endcase
      end
      ST_EMIT: begin
        unique case (ph_r)
          PH_ADDR: begin
            ps_raddr = idx_r[IDX_W-1:0];
            ph_nxt   = PH_KEY;
          end
          PH_KEY: begin
            out_vld_nxt  = 1'b1;
            out_pair_nxt = ps_rdata;
            out_last_nxt = (idx_r + CNT_W'(1) == cnt_r);
            out_ovf_nxt  = ovf_r;
            ph_nxt       = PH_UPD;
          end
          PH_UPD: begin
            if (out_fire) begin
              out_vld_nxt = 1'b0;
              idx_nxt     = idx_r + CNT_W'(1);
              ph_nxt      = PH_ADDR;
              if (out_last_r) begin
                state_nxt = ST_LOAD;
                cnt_nxt   = '0;
                ovf_nxt   = 1'b0;
              end
            end
          end
          default: ph_nxt = PH_ADDR;
        endcase
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      ph_r      <= PH_ADDR;
      pass_r    <= 1'b0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      idx_r     <= '0;
      kc_r      <= '0;
      rvld_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      pass_r    <= pass_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      idx_r     <= idx_nxt;
      kc_r      <= kc_nxt;
      rvld_r    <= rvld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raddr_r    <= raddr_nxt;
    acc_r      <= acc_nxt;
    key_r      <= key_nxt;
    pair_r     <= pair_nxt;
    out_pair_r <= out_pair_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Every scattered pair was counted, so its key's running count is never zero.
  a_scat_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAT && ph_r == PH_UPD) |-> (kc_rdata != '0))
    else $error("scatter found an empty key count");

  a_scat_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAT && ph_r == PH_UPD) |-> (cnt_dec < cnt_r))
    else $error("scatter slot beyond the loaded set");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PAIRS))
    else $error("pair count above capacity");

  a_out_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (state_r == ST_EMIT && ph_r == PH_UPD))
    else $error("result beat outside the emit phase");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (state_r == ST_LOAD && cnt_r == '0 && !ovf_r))
    else $error("set state not cleared after the final beat");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  import prs_pkg::*;

  localparam int MAX_PAIRS   = 64;
  localparam int KEY_BITS    = 8;
  localparam int QUIET_LIMIT = 20000;
  localparam int PRINT_LIMIT = 40;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
    logic             last;
    logic             ovf;
  } sorted_beat_t;

  logic clk;
  logic rst_n;

  prs_in_if  in_if ();
  prs_out_if out_if ();

  pair_radix_sort_top #(
    .MAX_PAIRS(MAX_PAIRS),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  logic [PAIR_W-1:0] set_pairs [$];
  logic              set_dropped;
  sorted_beat_t      sorted_beats_due [$];
  int                mismatch_count;
  int                quiet_cycles;
  int                in_gap_pct;
  int                out_stall_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
    end
    mismatch_count++;
  endtask

  // Tracks the set being loaded and, on its last pair, queues the sorted run.
  task automatic load_pair(input logic [VAL_W-1:0] fv, input logic [VAL_W-1:0] sv,
                           input logic lp);
    logic [PAIR_W-1:0] run [$];
    logic [PAIR_W-1:0] key;
    sorted_beat_t      beat;
    int                j;
    if (set_pairs.size() < MAX_PAIRS) begin
      set_pairs.insert(set_pairs.size(), {fv, sv});
    end else begin
      set_dropped = 1'b1;
    end
    if (lp) begin
      run = set_pairs;
      for (int i = 1; i < run.size(); i++) begin
        key = run[i];
        j = i - 1;
        while (j >= 0 && run[j] > key) begin
          run[j + 1] = run[j];
          j--;
        end
        run[j + 1] = key;
      end
      for (int i = 0; i < run.size(); i++) begin
        beat.first  = run[i][PAIR_W-1:VAL_W];
        beat.second = run[i][VAL_W-1:0];
        beat.last   = (i == run.size() - 1);
        beat.ovf    = set_dropped;
        sorted_beats_due.insert(sorted_beats_due.size(), beat);
      end
      set_pairs.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic send_pair(input logic [VAL_W-1:0] fv, input logic [VAL_W-1:0] sv,
                           input logic lp);
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.first_value  <= fv;
    in_if.second_value <= sv;
    in_if.last_pair    <= lp;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    load_pair(fv, sv, lp);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sorted_beats_due.size() != 0);
  endtask

  // Half the keys are spread over the full range, the rest crowd the ends to force ties.
  function automatic logic [VAL_W-1:0] rand_key();
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) begin
      return VAL_W'($urandom_range(0, 3));
    end else if (pick == 1) begin
      return VAL_W'($urandom_range(252, 255));
    end
    return VAL_W'($urandom);
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 1; i <= n; i++) begin
      send_pair(rand_key(), rand_key(), i == n);
    end
  endtask

  task automatic pick_idling();
    in_gap_pct    = 25 * $urandom_range(2);
    out_stall_pct = 25 * $urandom_range(2);
  endtask

  task automatic test_single_pairs();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair(8'hFF, 8'hFF, 1'b1);
    in_gap_pct    = 50;
    out_stall_pct = 50;
    send_pair(8'hAA, 8'h55, 1'b1);
  endtask

  task automatic test_key_extremes();
    in_gap_pct    = 25;
    out_stall_pct = 25;
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h00, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'h80, 8'h7F, 1'b0);
    send_pair(8'h7F, 8'h80, 1'b1);
  endtask

  task automatic test_tied_keys();
    in_gap_pct    = 50;
    out_stall_pct = 0;
    send_pair(8'h05, 8'h09, 1'b0);
    send_pair(8'h05, 8'h03, 1'b0);
    send_pair(8'h05, 8'h09, 1'b0);
    send_pair(8'hC8, 8'h03, 1'b0);
    send_pair(8'h05, 8'h03, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_set();
    pick_idling();
    send_random_set(MAX_PAIRS);
  endtask

  // The first set loses only its last pair, the second its last four pairs.
  task automatic test_overflow();
    pick_idling();
    send_random_set(MAX_PAIRS + 1);
    pick_idling();
    send_random_set(MAX_PAIRS + 4);
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < 110) begin
      pick_idling();
      n = ($urandom_range(7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      send_random_set(n);
      sent += n;
    end
  endtask

  task automatic test_quiet_tail();
    int sent;
    int n;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    sent = 0;
    while (sent < 40) begin
      n = $urandom_range(1, 12);
      send_random_set(n);
      sent += n;
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin : drive_ready
      int stall_left;
      stall_left = 0;
      forever begin
        @(posedge clk);
        if (stall_left == 0 && out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
          stall_left = $urandom_range(1, 4);
        end
        if (stall_left > 0) begin
          out_if.ready <= 1'b0;
          stall_left--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : check_beats
    sorted_beat_t due;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (sorted_beats_due.size() == 0) begin
        report_mismatch("beat with nothing due", {out_if.sorted_first, out_if.sorted_second},
                        0);
      end else begin
        due = sorted_beats_due.pop_front();
        if (out_if.sorted_first !== due.first) begin
          report_mismatch("sorted_first", out_if.sorted_first, due.first);
        end
        if (out_if.sorted_second !== due.second) begin
          report_mismatch("sorted_second", out_if.sorted_second, due.second);
        end
        if (out_if.last_result !== due.last) begin
          report_mismatch("last_result", out_if.last_result, due.last);
        end
        if (out_if.overflow !== due.ovf) begin
          report_mismatch("overflow", out_if.overflow, due.ovf);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
    set_dropped    = 1'b0;
    in_gap_pct     = 0;
    out_stall_pct  = 0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.first_value  <= '0;
    in_if.second_value <= '0;
    in_if.last_pair    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_pairs();
    test_key_extremes();
    test_tied_keys();
    test_full_set();
    test_overflow();
    test_random_sets();
    test_quiet_tail();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sorted_beats_due.size() != 0) begin
      report_mismatch("beats never delivered", sorted_beats_due.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
